// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file deq_checker.sv.
// Each macro names its assertion, samples at the rising edge of clk and is
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when the condition holds, the consequence holds.
`define DEQ_ASSERT_IMP(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when the condition holds, the consequence holds in
// the following cycle.
`define DEQ_ASSERT_NXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, controller states, read select and the command
// struct that the controller sends to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DATA_W     = 32;
	localparam int OP_W       = 3;
	localparam int COUNT_OUT_W = 5;
	localparam int STATUS_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_NONE       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_FRONT,
		S_BACK,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		RD_POP_ADDR,
		RD_FRONT_ADDR,
		RD_BACK_ADDR
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    exec;
		logic    cap_pop;
		logic    cap_front;
		logic    cap_back;
		rd_sel_t rd_sel;
	} ctl_cmd_t;

endpackage

`default_nettype wire

// ===== design/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue of signed 32-bit values
// Circular buffer with push and pop at both ends and a clear operation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation and push_value and raise start; the item is taken at a
//   rising edge where start is high and busy is low. busy stays high until
//   the result has been shown.
//   The result (popped_value, front_value, back_value, item_count, is_empty,
//   status) is valid for exactly one cycle while done is high. The next item can
//   be taken in the cycle after done, so the block handles one item at a time.
//   The sequence comes from the value store's single read port: each item reads
//   the popped entry in the cycle that updates the pointers and writes a pushed
//   value, then the new front and the new back, one per cycle.
//   A push to a full queue leaves it unchanged and reports status 1; a pop on
//   an empty queue reports status 2 and popped_value 0.
//   Reset empties the queue (front pointer and count to zero); the store is
//   not cleared, and a word read where it has not been written is never shown.
//   The receiver cannot stall: the next item overwrites the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic        [deq_pkg::OP_W-1:0]       operation,
	input  wire logic signed [deq_pkg::DATA_W-1:0]     push_value,
	output logic                                       done,
	output logic signed      [deq_pkg::DATA_W-1:0]     popped_value,
	output logic signed      [deq_pkg::DATA_W-1:0]     front_value,
	output logic signed      [deq_pkg::DATA_W-1:0]     back_value,
	output logic             [deq_pkg::COUNT_OUT_W-1:0] item_count,
	output logic                                       is_empty,
	output logic             [deq_pkg::STATUS_W-1:0]   status
);

	import deq_pkg::*;

	ctl_cmd_t cmd;

	// Sequence one item at a time
	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	// Hold the queue state and build the result
	deq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.push_value  (push_value),
		.popped_value(popped_value),
		.front_value (front_value),
		.back_value  (back_value),
		.item_count  (item_count),
		.is_empty    (is_empty),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== design/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl: sequencer of the double-ended queue
// Steps one item through update, pop read, front read, back read and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output deq_pkg::ctl_cmd_t       cmd
);

	import deq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance through the item sequence and issue datapath commands
	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		cmd.rd_sel    = RD_POP_ADDR;
		busy          = 1'b1;
		done          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec   = 1'b1;
				cmd.rd_sel = RD_POP_ADDR;
				state_nxt  = S_POP;
			end
			S_POP: begin
				cmd.cap_pop = 1'b1;
				cmd.rd_sel  = RD_FRONT_ADDR;
				state_nxt   = S_FRONT;
			end
			S_FRONT: begin
				cmd.cap_front = 1'b1;
				cmd.rd_sel    = RD_BACK_ADDR;
				state_nxt     = S_BACK;
			end
			S_BACK: begin
				cmd.cap_back = 1'b1;
				state_nxt    = S_RESP;
			end
			S_RESP: begin
				done      = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/deq_dpath.sv =====
// ----------------------------------------------------------------------------
// deq_dpath: datapath of the double-ended queue
// Front pointer, count, circular index math, value store and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_dpath #(
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire deq_pkg::ctl_cmd_t                     cmd,
	input  wire logic        [deq_pkg::OP_W-1:0]       operation,
	input  wire logic signed [deq_pkg::DATA_W-1:0]     push_value,
	output logic signed      [deq_pkg::DATA_W-1:0]     popped_value,
	output logic signed      [deq_pkg::DATA_W-1:0]     front_value,
	output logic signed      [deq_pkg::DATA_W-1:0]     back_value,
	output logic             [deq_pkg::COUNT_OUT_W-1:0] item_count,
	output logic                                       is_empty,
	output logic             [deq_pkg::STATUS_W-1:0]   status
);

	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	// Index that lies off places after base, wrapped at DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	logic        [OP_W-1:0]   op_q;
	logic signed [DATA_W-1:0] val_q;
	logic        [AW-1:0]     front_q;
	logic        [CW-1:0]     count_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] popped_q;
	logic signed [DATA_W-1:0] front_val_q;
	logic signed [DATA_W-1:0] back_val_q;

	logic        [AW-1:0]     front_nxt;
	logic        [CW-1:0]     count_nxt;
	status_t                  status_nxt;
	logic                     wr_req;
	logic        [AW-1:0]     waddr;
	logic        [AW-1:0]     pop_addr;
	logic        [AW-1:0]     back_addr;
	logic        [AW-1:0]     raddr;
	logic        [DATA_W-1:0] rdata;
	logic                     full;
	logic                     empty;
	logic                     pop_ok;

	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign back_addr = wrap_add(front_q, AW'(count_q - CW'(1)));
	assign pop_ok    = (status_q == STAT_OK) &&
		((op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK));

	// Decode the operation against the current pointer and count
	always_comb begin
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = STAT_OK;
		wr_req     = 1'b0;
		waddr      = front_q;
		pop_addr   = front_q;
		unique case (op_q)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					front_nxt = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
					waddr     = front_nxt;
					wr_req    = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					waddr     = wrap_add(front_q, AW'(count_q));
					wr_req    = 1'b1;
					count_nxt = count_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					front_nxt = wrap_add(front_q, AW'(1));
					count_nxt = count_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					pop_addr  = back_addr;
					count_nxt = count_q - CW'(1);
				end
			end
			OP_CLEAR: begin
				front_nxt = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// Select the store read address for this step
	always_comb begin
		unique case (cmd.rd_sel)
			RD_POP_ADDR:   raddr = pop_addr;
			RD_FRONT_ADDR: raddr = front_q;
			RD_BACK_ADDR:  raddr = back_addr;
			default:       raddr = front_q;
		endcase
	end

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (wr_req & cmd.exec),
		.waddr(waddr),
		.wdata(val_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Update queue state and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_NONE;
			front_q  <= '0;
			count_q  <= '0;
			status_q <= STAT_OK;
		end else begin
			if (cmd.load) begin
				op_q <= operation;
			end
			if (cmd.exec) begin
				front_q  <= front_nxt;
				count_q  <= count_nxt;
				status_q <= status_nxt;
			end
		end
	end

	// Capture the item and the result words
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= push_value;
		end
		if (cmd.cap_pop) begin
			popped_q <= pop_ok ? rdata : '0;
		end
		if (cmd.cap_front) begin
			front_val_q <= empty ? '0 : rdata;
		end
		if (cmd.cap_back) begin
			back_val_q <= empty ? '0 : rdata;
		end
	end

	assign popped_value = popped_q;
	assign front_value  = front_val_q;
	assign back_value   = back_val_q;
	assign item_count   = COUNT_OUT_W'(count_q);
	assign is_empty     = empty;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== design/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker: port-level checks of the double-ended queue
// Watches the command handshake and the result fields over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module deq_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  start,
	input wire logic                                  busy,
	input wire logic                                  done,
	input wire logic signed [deq_pkg::DATA_W-1:0]     popped_value,
	input wire logic        [deq_pkg::COUNT_OUT_W-1:0] item_count,
	input wire logic                                  is_empty,
	input wire logic        [deq_pkg::STATUS_W-1:0]   status
);

	import deq_pkg::*;

	// An accepted item makes the block busy
	`DEQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

	// One result per item: done is a single pulse per result
	`DEQ_ASSERT_NXT(a_done_single, done, !done, "done held for more than one cycle")

	// A result only appears while an item is in progress
	`DEQ_ASSERT_IMP(a_done_busy, done, busy, "done without busy")

	// A failed operation never returns a value
	`DEQ_ASSERT_IMP(a_fail_zero, done && (status != STAT_OK), popped_value == '0, "failed op popped a value")

	// An empty queue reports a zero count
	`DEQ_ASSERT_IMP(a_empty_count, done && is_empty, item_count == '0, "empty queue with nonzero count")

endmodule

bind double_ended_queue deq_checker u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.popped_value(popped_value),
	.item_count  (item_count),
	.is_empty    (is_empty),
	.status      (status)
);

`default_nettype wire

// ===== verif/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the double-ended queue
// Walks a short table of directed operations (empty pops, extreme values,
// spare codes, fill to full, wrap, clear), then about 1400 random operations
// that swing the queue between empty and full. A mirror of the queue predicts
// every result that the table does not give literally; results are checked field by field in arrival order.
// ----------------------------------------------------------------------------

module double_ended_queue_tb;

	import deq_pkg::*;

	localparam int QDEPTH         = 16;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int N_ROWS         = 17;

	// Operation codes the block treats as no operation
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0]      popped;
		logic [DATA_W-1:0]      front;
		logic [DATA_W-1:0]      back;
		logic [COUNT_OUT_W-1:0] count;
		logic                   empty;
		logic [STATUS_W-1:0]    stat;
	} deq_result_t;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
		int                reps;
		bit                literal;
		deq_result_t       want;
	} stim_row_t;

	localparam deq_result_t NO_RESULT       = '0;
	localparam deq_result_t EMPTY_POP_RESULT =
		'{popped: '0, front: '0, back: '0, count: '0, empty: 1'b1, stat: STAT_EMPTY};
	localparam deq_result_t EMPTY_OK_RESULT =
		'{popped: '0, front: '0, back: '0, count: '0, empty: 1'b1, stat: STAT_OK};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic        [OP_W-1:0]        operation;
	logic signed [DATA_W-1:0]      push_value;
	logic                          done;
	logic signed [DATA_W-1:0]      popped_value;
	logic signed [DATA_W-1:0]      front_value;
	logic signed [DATA_W-1:0]      back_value;
	logic        [COUNT_OUT_W-1:0] item_count;
	logic                          is_empty;
	logic        [STATUS_W-1:0]    status;

	// Mirror of the queue contents
	logic [DATA_W-1:0] mirror_slots [QDEPTH];
	logic [3:0]        mirror_head;
	logic [4:0]        mirror_fill;

	deq_result_t pending_results [$];
	stim_row_t   directed_rows [N_ROWS];
	int          mismatch_count = 0;
	int          idle_cycles    = 0;
	int          burst_left     = 0;
	bit          fill_bias      = 1'b1;

	double_ended_queue u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.push_value   (push_value),
		.done         (done),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.item_count   (item_count),
		.is_empty     (is_empty),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the mirror and return the result it should show
	function automatic deq_result_t apply_to_mirror(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] value);
		deq_result_t r;
		logic [3:0]  slot;
		r = NO_RESULT;
		r.stat = STAT_OK;
		case (op)
			OP_PUSH_FRONT: begin
				if (mirror_fill == QDEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					mirror_head = mirror_head - 4'd1;
					mirror_slots[mirror_head] = value;
					mirror_fill = mirror_fill + 5'd1;
				end
			end
			OP_PUSH_BACK: begin
				if (mirror_fill == QDEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					slot = mirror_head + mirror_fill[3:0];
					mirror_slots[slot] = value;
					mirror_fill = mirror_fill + 5'd1;
				end
			end
			OP_POP_FRONT: begin
				if (mirror_fill == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					r.popped = mirror_slots[mirror_head];
					mirror_head = mirror_head + 4'd1;
					mirror_fill = mirror_fill - 5'd1;
				end
			end
			OP_POP_BACK: begin
				if (mirror_fill == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					slot = mirror_head + mirror_fill[3:0] - 4'd1;
					r.popped = mirror_slots[slot];
					mirror_fill = mirror_fill - 5'd1;
				end
			end
			OP_CLEAR: begin
				mirror_fill = '0;
				mirror_head = '0;
			end
			default: ;
		endcase
		// Report both ends; a full queue wraps its back to just before the head
		if (mirror_fill != 0) begin
			slot = mirror_head + mirror_fill[3:0] - 4'd1;
			r.front = mirror_slots[mirror_head];
			r.back  = mirror_slots[slot];
		end
		r.count = mirror_fill;
		r.empty = (mirror_fill == 0);
		return r;
	endfunction

	// Drive one item, hold it until taken, then queue its expected result
	task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
			input bit literal, input deq_result_t want);
		deq_result_t predicted;
		int          gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start      <= 1'b1;
		operation  <= op;
		push_value <= value;
		do @(posedge clk); while (busy);
		predicted = apply_to_mirror(op, value);
		pending_results = {pending_results, (literal ? want : predicted)};
	endtask

	// Lower start and wait until every queued result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Pick a random operation, leaning toward filling or draining
	function automatic logic [OP_W-1:0] random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			return OP_CLEAR;
		if (pick < 5)
			return OP_NONE;
		if (pick < 7)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_LO : OP_SPARE_HI;
		if (pick < (fill_bias ? 75 : 35))
			return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("popped_value", want.popped, popped_value);
				check_field("front_value", want.front, front_value);
				check_field("back_value", want.back, back_value);
				check_field("item_count", 32'(want.count), 32'(item_count));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("status", 32'(want.stat), 32'(status));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_NONE;
		push_value  = '0;
		mirror_head = '0;
		mirror_fill = '0;

		// Directed table: literal rows carry their result, the rest use the mirror
		directed_rows = '{
			'{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1, EMPTY_POP_RESULT},
			'{OP_POP_BACK,   32'h0000_0000, 1, 1'b1, EMPTY_POP_RESULT},
			'{OP_NONE,       32'hFFFF_FFFF, 1, 1'b1, EMPTY_OK_RESULT},
			'{OP_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
				'{'0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, STAT_OK}},
			'{OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
				'{'0, 32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, STAT_OK}},
			'{OP_SPARE_LO,   32'hFFFF_FFFF, 1, 1'b0, NO_RESULT},
			'{OP_SPARE_HI,   32'h0000_0000, 1, 1'b0, NO_RESULT},
			'{OP_POP_FRONT,  32'h0000_0000, 1, 1'b0, NO_RESULT},
			'{OP_POP_BACK,   32'h0000_0000, 1, 1'b1,
				'{32'h7FFF_FFFF, '0, '0, 5'd0, 1'b1, STAT_OK}},
			'{OP_PUSH_FRONT, 32'h1234_5678, 1, 1'b0, NO_RESULT},
			'{OP_PUSH_BACK,  32'hA5A5_0000, 15, 1'b0, NO_RESULT},
			'{OP_PUSH_BACK,  32'h0000_0001, 1, 1'b0, NO_RESULT},
			'{OP_PUSH_FRONT, 32'h0000_0002, 1, 1'b0, NO_RESULT},
			'{OP_POP_FRONT,  32'h0000_0000, 1, 1'b0, NO_RESULT},
			'{OP_PUSH_BACK,  32'hDEAD_BEEF, 1, 1'b0, NO_RESULT},
			'{OP_CLEAR,      32'hFFFF_FFFF, 1, 1'b1, EMPTY_OK_RESULT},
			'{OP_POP_BACK,   32'h0000_0000, 1, 1'b1, EMPTY_POP_RESULT}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < N_ROWS; i++) begin
			for (int k = 0; k < directed_rows[i].reps; k++) begin
				send_item(directed_rows[i].op, directed_rows[i].value + k,
					directed_rows[i].literal, directed_rows[i].want);
			end
		end
		drain_results();

		// Random operations, swinging between fill and drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mirror_fill == QDEPTH)
				fill_bias = 1'b0;
			else if (mirror_fill == 0)
				fill_bias = 1'b1;
			else if ($urandom_range(0, 19) == 0)
				fill_bias = !fill_bias;
			send_item(random_op(), random_value(), 1'b0, NO_RESULT);
			if (n == RANDOM_ITEMS / 2)
				drain_results();
		end

		drain_results();
		repeat (12) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
